// ===== rtl/core/udc_pkg.sv =====
// ----------------------------------------------------------------------------
// udc_pkg
// Shared constants, types and the CRC-8 byte update for the UART write
// datagram builder.
// ----------------------------------------------------------------------------
package udc_pkg;

  localparam int unsigned DgramLen = 8;
  localparam int unsigned IdxW     = $clog2(DgramLen);
  localparam int unsigned ShW      = 8 * (DgramLen - 1);

  localparam logic [7:0] SyncByte  = 8'h05;
  localparam logic [7:0] WriteFlag = 8'h80;
  localparam logic [7:0] CrcPoly   = 8'h07;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(DgramLen - 1);

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_SLAVE_ADDRESS = 1'b0
  } reg_index_t;

  // Control from the top level to the serializer.
  typedef struct packed {
    logic load;     // take a new datagram in
    logic advance;  // emit the current byte and step on
  } ser_ctl_t;

  // One byte of CRC-8, data taken least significant bit first into a
  // left-shifting register.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data);
    logic [7:0] c;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      if (c[7] ^ data[b]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/udc_serializer.sv =====
// ----------------------------------------------------------------------------
// udc_serializer
// Holds one datagram and hands out its bytes in order, folding each byte
// into the running CRC so the eighth byte is the CRC itself.
// ----------------------------------------------------------------------------
module udc_serializer (
  input  logic                     clk,
  input  logic                     rst,
  input  udc_pkg::ser_ctl_t        ctl,
  input  logic [1:0]               slave_address,
  input  logic [6:0]               reg_address,
  input  logic [31:0]              value,
  output logic                     busy,
  output logic                     at_last,
  output logic [7:0]               cur_byte
);

  logic [udc_pkg::IdxW-1:0] idx;
  logic [udc_pkg::ShW-1:0]  sh;
  logic [7:0]               crc;

  assign at_last  = (idx == udc_pkg::LastIdx);
  assign cur_byte = at_last ? crc : sh[udc_pkg::ShW-1 -: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (ctl.load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (ctl.advance) begin
      if (at_last) begin
        busy <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh  <= {udc_pkg::SyncByte, {6'd0, slave_address},
              udc_pkg::WriteFlag | {1'b0, reg_address}, value};
      crc <= 8'h00;
    end else if (ctl.advance) begin
      sh  <= {sh[udc_pkg::ShW-9:0], 8'h00};
      crc <= udc_pkg::crc8_update(crc, sh[udc_pkg::ShW-1 -: 8]);
    end
  end

endmodule

// ===== rtl/core/uart_write_datagram_crc8.sv =====
// ----------------------------------------------------------------------------
// uart_write_datagram_crc8
// Turns a register write request into the eight-byte single-wire UART write
// datagram: sync, slave address, register address with write bit, four value
// bytes most significant first, and a CRC-8 (polynomial 0x07) byte.
// ----------------------------------------------------------------------------
// Each accepted request yields eight words on the byte channel, one per
// cycle when the downstream side does not stall. A request waits in an
// input register while the previous datagram is still going out, so
// back-to-back requests produce a continuous byte stream with no gap. The
// CRC is accumulated one byte per cycle as the bytes leave, and the eighth
// word carries it with last_byte set. The slave address comes from the
// configuration register at byte address 0 and is captured when a
// datagram starts; it should be written while the block is idle.
module uart_write_datagram_crc8 (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel.
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [6:0]  reg_address,
  input  logic [31:0] value,
  // Byte channel.
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  tx_byte,
  output logic        last_byte
);

  // Configuration register. The upper address bit selects the register
  // index; the low two bits are the byte offset within the word.
  logic [1:0] slave_address;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == udc_pkg::REG_SLAVE_ADDRESS);

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 2'd0;
    end else if (psel && penable && pwrite && reg_sel) begin
      slave_address <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_sel) begin
      prdata = {30'd0, slave_address};
    end
  end

  // Input register. It can be refilled the cycle after its request moves
  // into the serializer, which is well ahead of the next datagram start.
  logic        hold_full;
  logic [6:0]  hold_reg_address;
  logic [31:0] hold_value;

  // Serializer handshake.
  udc_pkg::ser_ctl_t ctl;
  logic              busy;
  logic              at_last;
  logic [7:0]        cur_byte;
  logic              out_free;

  assign req_stall   = hold_full;
  assign out_free    = !byte_valid || !byte_stall;
  assign ctl.advance = busy && out_free;
  assign ctl.load    = hold_full && (!busy || (ctl.advance && at_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      hold_full <= 1'b1;
    end else if (ctl.load) begin
      hold_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold_reg_address <= reg_address;
      hold_value       <= value;
    end
  end

  udc_serializer u_ser (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .slave_address (slave_address),
    .reg_address   (hold_reg_address),
    .value         (hold_value),
    .busy          (busy),
    .at_last       (at_last),
    .cur_byte      (cur_byte)
  );

  // Output register. A new byte is written when the serializer is busy and
  // the register is empty or its current word is being taken in this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (ctl.advance) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      tx_byte   <= cur_byte;
      last_byte <= at_last;
    end
  end

endmodule
